/* hw/rtl/svpwm_pkg.sv */
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared constants, register indexes and helper functions for the space vector
// PWM compare calculator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

	localparam logic [15:0] PWM_PERIOD_RST  = 16'd2400;
	localparam logic [15:0] MIN_COMPARE_RST = 16'd100;
	localparam logic [15:0] MAX_OFFSET_RST  = 16'd10;
	localparam logic [15:0] TIME_GAIN_RST   = 16'd32768;

	localparam logic [1:0] REG_PWM_PERIOD  = 2'd0;
	localparam logic [1:0] REG_MIN_COMPARE = 2'd1;
	localparam logic [1:0] REG_MAX_OFFSET  = 2'd2;
	localparam logic [1:0] REG_TIME_GAIN   = 2'd3;

	localparam logic signed [33:0] SQRT3_Q15  = 34'sd56755;
	localparam logic signed [33:0] ROUND_Q15  = 34'sd16384;

	localparam logic [2:0] SECTOR_ZERO = 3'd0;
	localparam logic [2:0] SECTOR_1    = 3'd1;
	localparam logic [2:0] SECTOR_2    = 3'd2;
	localparam logic [2:0] SECTOR_3    = 3'd3;
	localparam logic [2:0] SECTOR_4    = 3'd4;
	localparam logic [2:0] SECTOR_5    = 3'd5;
	localparam logic [2:0] SECTOR_6    = 3'd6;

	// sign pattern {c>0, b>0, a>0} to sector
	function automatic logic [2:0] sector_of_n(input logic [2:0] n);
		logic [2:0] s;
		case (n)
			3'd1:    s = SECTOR_2;
			3'd2:    s = SECTOR_6;
			3'd3:    s = SECTOR_1;
			3'd4:    s = SECTOR_4;
			3'd5:    s = SECTOR_3;
			3'd6:    s = SECTOR_5;
			default: s = SECTOR_ZERO;
		endcase
		return s;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/svpwm_compare_calculator.sv */
// ----------------------------------------------------------------------------
// svpwm_compare_calculator
// Seven-segment space vector PWM: alpha/beta voltage pair in, sector and three
// phase timer compares out, as a six-stage pipeline.
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the output stalls; each stage loads whenever it is empty or
//   the stage after it moves, so bubbles close up under output back-pressure
// reset: arst_n clears all stage valid bits and loads the register defaults
//   (period 2400, min 100, offset 10, gain 32768)
module svpwm_compare_calculator
	import svpwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // v_alpha[15:0], v_beta[31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // compare_a, compare_b, compare_c, sector, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] pwm_period_q, min_compare_q, max_offset_q, time_gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q  <= PWM_PERIOD_RST;
			min_compare_q <= MIN_COMPARE_RST;
			max_offset_q  <= MAX_OFFSET_RST;
			time_gain_q   <= TIME_GAIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PWM_PERIOD:  pwm_period_q  <= cfg_data;
				REG_MIN_COMPARE: min_compare_q <= cfg_data;
				REG_MAX_OFFSET:  max_offset_q  <= cfg_data;
				REG_TIME_GAIN:   time_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld1, ld2, ld3, ld4, ld5, ld6;

	assign ld6 = !v_s6 || m_axis_tready;
	assign ld5 = !v_s5 || ld6;
	assign ld4 = !v_s4 || ld5;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;

	assign s_axis_tready = ld1;
	assign m_axis_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= s_axis_tvalid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
		end
	end

	// stage 1: alpha times sqrt3
	logic signed [15:0] v_alpha, v_beta;
	logic signed [33:0] va_ext;
	logic signed [33:0] prod_s1;
	logic signed [15:0] vb_s1;

	assign v_alpha = s_axis_tdata[15:0];
	assign v_beta  = s_axis_tdata[31:16];
	assign va_ext  = {{18{v_alpha[15]}}, v_alpha};

	always_ff @(posedge clk) begin
		if (ld1 && s_axis_tvalid) begin
			prod_s1 <= va_ext * SQRT3_Q15;
			vb_s1   <= v_beta;
		end
	end

	// stage 2: reference voltages a, b, c
	logic signed [33:0] prod_rnd;
	logic signed [19:0] p_ext, vb_ext, diff_b, diff_c, half_b, half_c;
	logic signed [15:0] a_s2, b_s2, c_s2;

	assign prod_rnd = prod_s1 + ROUND_Q15;
	assign p_ext    = {prod_rnd[33], prod_rnd[33:15]};
	assign vb_ext   = {{4{vb_s1[15]}}, vb_s1};
	assign diff_b   = p_ext - vb_ext + 20'sd1;
	assign diff_c   = -p_ext - vb_ext + 20'sd1;
	assign half_b   = diff_b >>> 1;
	assign half_c   = diff_c >>> 1;

	always_ff @(posedge clk) begin
		if (ld2 && v_s1) begin
			a_s2 <= vb_s1;
			b_s2 <= sat16(half_b);
			c_s2 <= sat16(half_c);
		end
	end

	// stage 3: gain products and sector
	logic signed [33:0] a_ext, nb_ext, nc_ext, g_ext;
	logic signed [33:0] xp_s3, yp_s3, zp_s3;
	logic [2:0] n_sig;
	logic [2:0] sector_s3;

	assign a_ext  = {{18{a_s2[15]}}, a_s2};
	assign nb_ext = -{{18{b_s2[15]}}, b_s2};
	assign nc_ext = -{{18{c_s2[15]}}, c_s2};
	assign g_ext  = {18'd0, time_gain_q};
	assign n_sig  = {c_s2 > 16'sd0, b_s2 > 16'sd0, a_s2 > 16'sd0};

	always_ff @(posedge clk) begin
		if (ld3 && v_s2) begin
			xp_s3     <= a_ext * g_ext;
			yp_s3     <= nc_ext * g_ext;
			zp_s3     <= nb_ext * g_ext;
			sector_s3 <= sector_of_n(n_sig);
		end
	end

	// stage 4: round, saturate, pick tx and ty
	logic signed [33:0] xr, yr, zr;
	logic signed [15:0] x_v, y_v, z_v;
	logic signed [16:0] x_e, y_e, z_e;
	logic signed [16:0] tx_n, ty_n;
	logic signed [16:0] tx_s4, ty_s4;
	logic [2:0] sector_s4;

	assign xr  = xp_s3 + ROUND_Q15;
	assign yr  = yp_s3 + ROUND_Q15;
	assign zr  = zp_s3 + ROUND_Q15;
	assign x_v = sat16({xr[33], xr[33:15]});
	assign y_v = sat16({yr[33], yr[33:15]});
	assign z_v = sat16({zr[33], zr[33:15]});
	assign x_e = {x_v[15], x_v};
	assign y_e = {y_v[15], y_v};
	assign z_e = {z_v[15], z_v};

	always_comb begin
		case (sector_s3)
			SECTOR_1: begin tx_n = -z_e; ty_n = x_e;  end
			SECTOR_2: begin tx_n = z_e;  ty_n = y_e;  end
			SECTOR_3: begin tx_n = x_e;  ty_n = -y_e; end
			SECTOR_4: begin tx_n = -x_e; ty_n = z_e;  end
			SECTOR_5: begin tx_n = -y_e; ty_n = -z_e; end
			SECTOR_6: begin tx_n = y_e;  ty_n = -x_e; end
			default:  begin tx_n = '0;   ty_n = '0;   end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld4 && v_s3) begin
			tx_s4     <= tx_n;
			ty_s4     <= ty_n;
			sector_s4 <= sector_s3;
		end
	end

	// stage 5: compares and limiting
	logic signed [19:0] ts_ext, tx_ext, ty_ext;
	logic signed [19:0] sum_sm, sum_md, sum_bg;
	logic signed [19:0] q_sm, q_md, q_bg;
	logic signed [19:0] hi_lim, lo_lim;
	logic signed [17:0] zero_diff;
	logic [15:0] sm_s5, md_s5, bg_s5, zv_s5;
	logic [2:0]  sector_s5;

	function automatic logic [15:0] limit_cmp(input logic signed [19:0] v,
			input logic signed [19:0] hi, input logic signed [19:0] lo);
		logic signed [19:0] r;
		r = (v > hi) ? hi : v;
		if (r < lo) r = lo;
		return r[15:0];
	endfunction

	assign ts_ext    = {3'd0, pwm_period_q, 1'b0};
	assign tx_ext    = {{3{tx_s4[16]}}, tx_s4};
	assign ty_ext    = {{3{ty_s4[16]}}, ty_s4};
	assign sum_sm    = ts_ext - tx_ext - ty_ext;
	assign sum_md    = ts_ext + tx_ext - ty_ext;
	assign sum_bg    = ts_ext + tx_ext + ty_ext;
	assign q_sm      = sum_sm >>> 2;
	assign q_md      = sum_md >>> 2;
	assign q_bg      = sum_bg >>> 2;
	assign hi_lim    = {4'd0, pwm_period_q} - {4'd0, max_offset_q};
	assign lo_lim    = {4'd0, min_compare_q};
	assign zero_diff = {2'd0, pwm_period_q} - {2'd0, min_compare_q};

	always_ff @(posedge clk) begin
		if (ld5 && v_s4) begin
			sm_s5     <= limit_cmp(q_sm, hi_lim, lo_lim);
			md_s5     <= limit_cmp(q_md, hi_lim, lo_lim);
			bg_s5     <= limit_cmp(q_bg, hi_lim, lo_lim);
			zv_s5     <= zero_diff[17] ? 16'd0 : zero_diff[15:0];
			sector_s5 <= sector_s4;
		end
	end

	// stage 6: phase routing into the output register
	logic [15:0] ca_n, cb_n, cc_n;

	always_comb begin
		case (sector_s5)
			SECTOR_1: begin ca_n = sm_s5; cb_n = md_s5; cc_n = bg_s5; end
			SECTOR_2: begin ca_n = md_s5; cb_n = sm_s5; cc_n = bg_s5; end
			SECTOR_3: begin ca_n = bg_s5; cb_n = sm_s5; cc_n = md_s5; end
			SECTOR_4: begin ca_n = bg_s5; cb_n = md_s5; cc_n = sm_s5; end
			SECTOR_5: begin ca_n = md_s5; cb_n = bg_s5; cc_n = sm_s5; end
			SECTOR_6: begin ca_n = sm_s5; cb_n = bg_s5; cc_n = md_s5; end
			default:  begin ca_n = zv_s5; cb_n = zv_s5; cc_n = zv_s5; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld6 && v_s5) begin
			m_axis_tdata <= {5'd0, sector_s5, cc_n, cb_n, ca_n};
		end
	end

endmodule
